### hdl/bidol_pkg.sv
package bidol_pkg;

    // List geometry
    localparam int MAX_ENTRIES = 64;
    localparam int PTR_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 8;
    localparam int COUNT_OUT_W = 7;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        FN_PUSH  = 2'd0,
        FN_POP   = 2'd1,
        FN_TOUCH = 2'd2,
        FN_NOP   = 2'd3
    } func_t;

    // Result status carried on m_tuser
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_HEAD_RD,
        S_HEAD_LAT,
        S_RESULT
    } state_t;

endpackage

### hdl/buffer_id_order_list_unit.sv
// Ordered list of buffer frame ids, used as a free-frame FIFO or an LRU order.
// Input channel s_*: one item per operation; s_tuser selects push, pop,
// touch (move id to tail) or no-op, s_tdata carries the frame id.
// Output channel m_*: exactly one result item per input item, in order;
// m_tuser is the status, m_tdata the popped/moved id, head id, head valid
// and entry count after the operation.
// The list lives in a circular buffer in one RAM with registered read,
// addressed from a head pointer; a cached head id serves pop results.
// Push and pop refresh the cached head id with a RAM read before the result
// (a pop that empties the list skips the read); a dropped push, a no-op and
// a pop or touch on an empty list go straight to the result. A touch scans
// the RAM one entry per cycle from the head, then on a match shifts the
// entries behind it down one per cycle through the same RAM ports; it also
// refreshes the head id before its result. One item is in work
// at a time; s_tready is high while the sequencer is idle.
// A finished result waits in the output register, so the next item is
// accepted while the receiver stalls; that item halts only when its own
// result is ready and the previous one has not been taken.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; no clearing pass is needed since only occupied slots are read.
module buffer_id_order_list_unit
    import bidol_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] buffer_id
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] result_id, [15:8] head_id,
                                   // [16] head_valid, [23:17] entry_count
    output logic [1:0]  m_tuser    // [1:0] status
);

    state_t                 state_reg, state_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [ID_W-1:0]        head_id_reg, head_id_next;
    logic [ID_W-1:0]        id_reg, id_next;
    status_t                status_reg, status_next;
    logic [ID_W-1:0]        result_reg, result_next;
    logic [CNT_W-1:0]       off_reg, off_next;
    logic                   pend_reg, pend_next;
    logic [CNT_W-1:0]       pend_off_reg, pend_off_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [ID_W-1:0]        m_result_reg, m_result_next;
    logic [ID_W-1:0]        m_head_reg, m_head_next;
    logic                   m_hvalid_reg, m_hvalid_next;
    logic [COUNT_OUT_W-1:0] m_count_reg, m_count_next;

    logic                   ram_we;
    logic [PTR_W-1:0]       ram_waddr;
    logic [ID_W-1:0]        ram_wdata;
    logic                   ram_re;
    logic [PTR_W-1:0]       ram_raddr;
    logic [ID_W-1:0]        ram_rdata;

    // Map a list position to a RAM slot, wrapping around the buffer
    function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(MAX_ENTRIES)) begin
            sum = sum - (CNT_W+1)'(MAX_ENTRIES);
        end
        return PTR_W'(sum);
    endfunction

    bidol_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_ENTRIES)
    ) u_order_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            cnt_reg     <= '0;
            head_id_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            head_id_reg <= head_id_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
        off_reg      <= off_next;
        pend_off_reg <= pend_off_next;
        m_status_reg <= m_status_next;
        m_result_reg <= m_result_next;
        m_head_reg   <= m_head_next;
        m_hvalid_reg <= m_hvalid_next;
        m_count_reg  <= m_count_next;
    end

    // Sequencer: operation start, search, shift, head refresh, result
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        head_id_next  = head_id_reg;
        id_next       = id_reg;
        status_next   = status_reg;
        result_next   = result_reg;
        off_next      = off_reg;
        pend_next     = pend_reg;
        pend_off_next = pend_off_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_result_next = m_result_reg;
        m_head_next   = m_head_reg;
        m_hvalid_next = m_hvalid_reg;
        m_count_next  = m_count_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_wdata     = s_tdata;
        ram_re        = 1'b0;
        ram_raddr     = head_reg;
        s_tready      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    id_next     = s_tdata;
                    status_next = STAT_OK;
                    result_next = '0;
                    unique case (func_t'(s_tuser))
                        FN_PUSH: begin
                            if (cnt_reg == CNT_W'(MAX_ENTRIES)) begin
                                status_next = STAT_FULL;
                                state_next  = S_RESULT;
                            end else begin
                                // append at the tail
                                ram_we     = 1'b1;
                                ram_waddr  = slot_addr(head_reg, cnt_reg);
                                ram_wdata  = s_tdata;
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = S_HEAD_RD;
                            end
                        end
                        FN_POP: begin
                            if (cnt_reg == '0) begin
                                status_next = STAT_EMPTY;
                                state_next  = S_RESULT;
                            end else begin
                                // return cached head, advance the head pointer
                                result_next = head_id_reg;
                                head_next   = (head_reg == PTR_W'(MAX_ENTRIES - 1)) ?
                                              '0 : head_reg + 1'b1;
                                cnt_next    = cnt_reg - 1'b1;
                                state_next  = S_HEAD_RD;
                            end
                        end
                        FN_TOUCH: begin
                            if (cnt_reg == '0) begin
                                status_next = STAT_NOT_FOUND;
                                state_next  = S_RESULT;
                            end else begin
                                off_next   = '0;
                                pend_next  = 1'b0;
                                state_next = S_SEARCH;
                            end
                        end
                        FN_NOP: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // compare the entry read last cycle while reading the next one
                if (pend_reg && ram_rdata == id_reg) begin
                    result_next = id_reg;
                    off_next    = pend_off_reg + 1'b1;
                    pend_next   = 1'b0;
                    state_next  = S_SHIFT;
                end else if (pend_reg && pend_off_reg == cnt_reg - 1'b1) begin
                    status_next = STAT_NOT_FOUND;
                    pend_next   = 1'b0;
                    state_next  = S_HEAD_RD;
                end else if (off_reg < cnt_reg) begin
                    ram_re        = 1'b1;
                    ram_raddr     = slot_addr(head_reg, off_reg);
                    pend_next     = 1'b1;
                    pend_off_next = off_reg;
                    off_next      = off_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
            end

            S_SHIFT: begin
                // move each entry behind the match one position toward the head
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_addr(head_reg, pend_off_reg - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (off_reg < cnt_reg) begin
                    ram_re        = 1'b1;
                    ram_raddr     = slot_addr(head_reg, off_reg);
                    pend_next     = 1'b1;
                    pend_off_next = off_reg;
                    off_next      = off_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        // place the touched id at the tail
                        ram_we     = 1'b1;
                        ram_waddr  = slot_addr(head_reg, cnt_reg - 1'b1);
                        ram_wdata  = id_reg;
                        state_next = S_HEAD_RD;
                    end
                end
            end

            S_HEAD_RD: begin
                // refresh the cached head id
                if (cnt_reg == '0) begin
                    head_id_next = '0;
                    state_next   = S_RESULT;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = head_reg;
                    state_next = S_HEAD_LAT;
                end
            end

            S_HEAD_LAT: begin
                head_id_next = ram_rdata;
                state_next   = S_RESULT;
            end

            S_RESULT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_result_next = result_reg;
                    m_head_next   = head_id_reg;
                    m_hvalid_next = (cnt_reg != '0);
                    m_count_next  = COUNT_OUT_W'(cnt_reg);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_count_reg, m_hvalid_reg, m_head_reg, m_result_reg};

`ifndef SYNTHESIS
    // Count never exceeds the list depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above list depth");

    // Count changes only when an item is accepted
    a_cnt_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) |=> $stable(cnt_reg))
        else $error("entry count changed outside an accept");

    // Accepted push into a non-full list adds one entry
    a_push_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == FN_PUSH && cnt_reg != CNT_W'(MAX_ENTRIES))
        |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push did not add an entry");

    // Reported head valid agrees with reported count
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16] == (m_tdata[23:17] != '0)))
        else $error("head valid disagrees with entry count");
`endif

endmodule

### hdl/bidol_ram.sv
module bidol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### dv/buffer_id_order_list_unit_test.sv
module buffer_id_order_list_unit_test;
    import bidol_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_OPS   = 1000;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_HOLD_AT = 200;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 100;

    // One operation offered on the input channel
    typedef struct {
        func_t      op;
        logic [7:0] frame_id;
        bit         drain_first;
    } list_op_t;

    // One result item as the list should report it
    typedef struct {
        status_t    status;
        logic [7:0] result_id;
        logic [7:0] head_id;
        logic       head_valid;
        logic [6:0] entry_count;
    } list_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];
    logic [7:0]   frame_order[$];

    int total_ops;
    int ops_accepted;
    int results_seen;
    int error_count;
    int send_gap;
    int recv_stall;
    bit quiet;

    int pushes_stored, pushes_dropped, pops_done, pops_empty;
    int touches_moved, touches_missed, nops_seen;

    buffer_id_order_list_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one operation to the shadow list and queue the result it yields
    task automatic predict_list_op(input list_op_t item);
        list_result_t res;
        int hit;
        res.status    = STAT_OK;
        res.result_id = 8'd0;
        hit = -1;
        case (item.op)
            FN_PUSH: begin
                if (frame_order.size() >= MAX_ENTRIES) begin
                    res.status = STAT_FULL;
                    pushes_dropped++;
                end else begin
                    frame_order.push_back(item.frame_id);
                    pushes_stored++;
                end
            end
            FN_POP: begin
                if (frame_order.size() == 0) begin
                    res.status = STAT_EMPTY;
                    pops_empty++;
                end else begin
                    res.result_id = frame_order.pop_front();
                    pops_done++;
                end
            end
            FN_TOUCH: begin
                for (int i = 0; i < frame_order.size(); i++) begin
                    if (hit < 0 && frame_order[i] == item.frame_id) hit = i;
                end
                if (hit < 0) begin
                    res.status = STAT_NOT_FOUND;
                    touches_missed++;
                end else begin
                    frame_order.delete(hit);
                    frame_order.push_back(item.frame_id);
                    res.result_id = item.frame_id;
                    touches_moved++;
                end
            end
            default: begin
                nops_seen++;
            end
        endcase
        res.head_valid  = (frame_order.size() != 0);
        res.head_id     = res.head_valid ? frame_order[0] : 8'd0;
        res.entry_count = 7'(frame_order.size());
        expected_results.push_back(res);
    endtask

    // Compare one result item with the oldest expectation, field by field
    task automatic check_list_result();
        list_result_t want;
        if (expected_results.size() == 0) begin
            $error("result item with nothing expected: tuser %0d tdata %h", m_tuser, m_tdata);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            if (m_tuser != want.status) begin
                $error("status: expected %0d, actual %0d", want.status, m_tuser);
                error_count++;
            end
            if (m_tdata[7:0] != want.result_id) begin
                $error("result_id: expected %0d, actual %0d", want.result_id, m_tdata[7:0]);
                error_count++;
            end
            if (m_tdata[15:8] != want.head_id) begin
                $error("head_id: expected %0d, actual %0d", want.head_id, m_tdata[15:8]);
                error_count++;
            end
            if (m_tdata[16] != want.head_valid) begin
                $error("head_valid: expected %0d, actual %0d", want.head_valid, m_tdata[16]);
                error_count++;
            end
            if (m_tdata[23:17] != want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d",
                       want.entry_count, m_tdata[23:17]);
                error_count++;
            end
        end
    endtask

    task automatic add_op(input func_t op, input logic [7:0] frame_id);
        list_op_t item;
        item.op          = op;
        item.frame_id    = frame_id;
        item.drain_first = 1'b0;
        pending_ops.push_back(item);
    endtask

    // Build the whole stimulus: directed corner cases, then random segments
    task automatic build_stimulus();
        int seg_mode;
        int seg_len;
        int roll;
        int made;
        bit narrow;
        logic [3:0] seg_hi;
        logic [7:0] fid;
        func_t op;

        // Empty list corners, no-op, extreme ids, duplicates
        add_op(FN_TOUCH, 8'd7);
        add_op(FN_POP,   8'd255);
        add_op(FN_NOP,   8'd255);
        add_op(FN_PUSH,  8'd0);
        add_op(FN_PUSH,  8'd255);
        add_op(FN_PUSH,  8'h5A);
        add_op(FN_PUSH,  8'h5A);
        add_op(FN_PUSH,  8'hA5);
        add_op(FN_TOUCH, 8'h5A);
        add_op(FN_TOUCH, 8'h33);
        add_op(FN_TOUCH, 8'd0);
        add_op(FN_TOUCH, 8'hA5);
        add_op(FN_NOP,   8'd0);
        add_op(FN_POP,   8'd0);
        add_op(FN_POP,   8'd0);
        add_op(FN_POP,   8'd0);
        add_op(FN_POP,   8'd0);
        add_op(FN_POP,   8'd0);
        add_op(FN_POP,   8'd0);
        add_op(FN_PUSH,  8'h80);
        add_op(FN_PUSH,  8'h01);
        add_op(FN_TOUCH, 8'h80);

        // Segments: fill (push-heavy, toward full and overflow), drain (pop-heavy, toward empty), mixed
        made = 0;
        while (made < RANDOM_OPS) begin
            seg_mode = $urandom_range(0, 2);
            seg_len  = $urandom_range(40, 120);
            narrow   = 1'($urandom_range(0, 1));
            seg_hi   = 4'($urandom_range(0, 15));
            for (int k = 0; k < seg_len && made < RANDOM_OPS; k++) begin
                roll = $urandom_range(0, 99);
                case (seg_mode)
                    0: op = (roll < 75) ? FN_PUSH : (roll < 93) ? FN_TOUCH :
                            (roll < 98) ? FN_POP : FN_NOP;
                    1: op = (roll < 70) ? FN_POP : (roll < 80) ? FN_PUSH :
                            (roll < 95) ? FN_TOUCH : FN_NOP;
                    default: op = (roll < 35) ? FN_PUSH : (roll < 65) ? FN_POP :
                                  (roll < 95) ? FN_TOUCH : FN_NOP;
                endcase
                if (narrow) fid = {seg_hi, 4'($urandom_range(0, 15))};
                else        fid = 8'($urandom_range(0, 255));
                add_op(op, fid);
                made++;
            end
        end

        // Midway the sender waits until every outstanding result has come
        pending_ops[pending_ops.size() / 2].drain_first = 1'b1;
    endtask

    // Driver: offer pending items, predict each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_list_op(pending_ops[0]);
                pending_ops.pop_front();
                ops_accepted++;
                quiet = (ops_accepted >= total_ops - QUIET_TAIL);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_ops[0].drain_first && expected_results.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (!quiet && !(s_tvalid && !s_tready) && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 5) - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_ops[0].frame_id;
                s_tuser  <= pending_ops[0].op;
            end
        end
    end

    // Monitor: check accepted results, stall the result channel at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_list_result();
                results_seen++;
                // hold off long enough for the block to back up its input
                if (results_seen == LONG_HOLD_AT) recv_stall = LONG_HOLD;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(1, 5) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("watchdog: no item accepted for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset, stimulus and end of run
    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        s_tuser      = FN_NOP;
        m_tready     = 1'b0;
        ops_accepted = 0;
        results_seen = 0;
        error_count  = 0;
        send_gap     = 0;
        recv_stall   = 0;
        quiet        = 1'b0;
        pushes_stored = 0; pushes_dropped = 0; pops_done = 0; pops_empty = 0;
        touches_moved = 0; touches_missed = 0; nops_seen = 0;

        build_stimulus();
        total_ops = pending_ops.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_accepted < total_ops || expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end

        $display("ran %0d operations, %0d results: %0d pushes stored, %0d dropped on full,",
                 total_ops, results_seen, pushes_stored, pushes_dropped);
        $display("  %0d pops, %0d on empty, %0d touches moved, %0d missed, %0d no-ops",
                 pops_done, pops_empty, touches_moved, touches_missed, nops_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
